@@ rtl/uft_pkg.sv @@
// Package for the identifier forwarding table: table geometry, entry and
// result types, state and register index codes. No dependencies.
`default_nettype none

package uft_pkg;

  localparam int unsigned TableEntries = 32;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = $clog2(TableEntries + 1);

  localparam logic [31:0] IdBroadcast = 32'd0;
  localparam logic [31:0] IdService   = 32'd1;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_STACK   = 2'd1,
    KIND_EXT_ONE = 2'd2,
    KIND_EXT_TWO = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_MASTER_ENABLED = 2'd0,
    CFG_EXT_ONE_MASTER = 2'd1,
    CFG_EXT_TWO_MASTER = 2'd2,
    CFG_STACK_COUNT    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  kind;
    logic [7:0]  option;
  } entry_t;

  typedef struct packed {
    logic       add_done;
    logic       table_full;
    logic       found;
    logic       send_stack;
    logic [7:0] stack_addr;
    logic       broadcast_stacks;
    logic       send_ext_one;
    logic       send_ext_two;
    logic       to_service;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/uid_forwarding_table_core.sv @@
// Identifier forwarding table: append-only table memory with a first-match
// search that reads one entry per cycle. Depends on uft_pkg.
`default_nettype none

// An add, a forward of the broadcast or service identifier and a lookup in
// an empty table pass from input transfer through the EMIT state to the
// output register. Other lookups first scan up to 32 entries in SEARCH,
// stopping at a match or the last entry: the single read port of the
// table memory delivers one entry per cycle. One item is in work at a time;
// the input stalls until its result has moved into the output register,
// which then holds it while the next item is taken. Configuration writes
// take effect at once and are expected only while no item is in work.
module uid_forwarding_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [31:0] device_id_i,
  input  wire logic [1:0]  dest_kind_i,
  input  wire logic [7:0]  dest_option_i,
  input  wire logic        from_network_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             add_done_o,
  output logic             table_full_o,
  output logic             found_o,
  output logic             send_stack_o,
  output logic [7:0]       stack_addr_o,
  output logic             broadcast_stacks_o,
  output logic             send_ext_one_o,
  output logic             send_ext_two_o,
  output logic             to_service_o
);
  import uft_pkg::*;

  state_e             state_q, state_d;
  logic               master_q, ext1_q, ext2_q;
  logic [3:0]         stack_cnt_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [31:0]        id_q;
  result_t            res_q, res_d;
  result_t            out_q;
  logic               out_valid_q;
  entry_t             entry_mem_q [TableEntries];
  entry_t             rd_entry_q;
  logic               mem_we;
  logic [IdxW-1:0]    raddr;
  entry_t             wdata;
  logic               in_xfer;
  logic               out_free;
  logic               is_full;
  logic               last_idx;

  function automatic result_t fwd_result(logic hit, logic [1:0] kind, logic [7:0] option,
                                         logic master, logic e1, logic e2);
    result_t r;
    r = '0;
    r.found = hit;
    if (hit && kind == KIND_STACK) begin
      r.send_stack = 1'b1;
      r.stack_addr = option;
    end else if (master) begin
      if (hit && kind == KIND_EXT_ONE) begin
        r.send_ext_one = e1;
      end else if (hit && kind == KIND_EXT_TWO) begin
        r.send_ext_two = e2;
      end else begin
        r.send_ext_one = e1;
        r.send_ext_two = e2;
      end
    end
    return r;
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_full    = (count_q == CntW'(TableEntries));
  assign last_idx   = ((CntW'(idx_q) + CntW'(1)) == count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (mode_i && device_id_i != IdBroadcast && device_id_i != IdService &&
              count_q != '0) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SEARCH: begin
        if (rd_entry_q.id == id_q || last_idx) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_d   = res_q;
    count_d = count_q;
    idx_d   = idx_q;
    mem_we  = 1'b0;
    raddr   = '0;
    wdata   = '{id: device_id_i, kind: dest_kind_i, option: dest_option_i};
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_xfer) begin
          res_d = '0;
          if (!mode_i) begin
            if (is_full) begin
              res_d.table_full = 1'b1;
            end else begin
              res_d.add_done = 1'b1;
              mem_we         = 1'b1;
              count_d        = count_q + CntW'(1);
            end
          end else if (device_id_i == IdBroadcast) begin
            res_d.broadcast_stacks = (stack_cnt_q != '0);
            res_d.send_ext_one     = ext1_q;
            res_d.send_ext_two     = ext2_q;
          end else if (device_id_i == IdService) begin
            res_d.to_service = from_network_i;
          end else begin
            res_d = fwd_result(1'b0, KIND_NONE, 8'd0, master_q, ext1_q, ext2_q);
          end
        end
      end
      ST_SEARCH: begin
        raddr = idx_q + IdxW'(1);
        idx_d = idx_q + IdxW'(1);
        if (rd_entry_q.id == id_q) begin
          res_d = fwd_result(1'b1, rd_entry_q.kind, rd_entry_q.option,
                             master_q, ext1_q, ext2_q);
        end else if (last_idx) begin
          res_d = fwd_result(1'b0, KIND_NONE, 8'd0, master_q, ext1_q, ext2_q);
        end
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[count_q[IdxW-1:0]] <= wdata;
    end
    rd_entry_q <= entry_mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      master_q    <= 1'b0;
      ext1_q      <= 1'b0;
      ext2_q      <= 1'b0;
      stack_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MASTER_ENABLED: master_q    <= cfg_data_i[0];
          CFG_EXT_ONE_MASTER: ext1_q      <= cfg_data_i[0];
          CFG_EXT_TWO_MASTER: ext2_q      <= cfg_data_i[0];
          CFG_STACK_COUNT:    stack_cnt_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
    if (in_xfer) begin
      id_q <= device_id_i;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign add_done_o         = out_q.add_done;
  assign table_full_o       = out_q.table_full;
  assign found_o            = out_q.found;
  assign send_stack_o       = out_q.send_stack;
  assign stack_addr_o       = out_q.stack_addr;
  assign broadcast_stacks_o = out_q.broadcast_stacks;
  assign send_ext_one_o     = out_q.send_ext_one;
  assign send_ext_two_o     = out_q.send_ext_two;
  assign to_service_o       = out_q.to_service;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableEntries))
    else $error("entry count beyond table size");

  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> CntW'(idx_q) < count_q)
    else $error("search index past filled entries");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !mode_i && !is_full |=> count_q == $past(count_q) + CntW'(1))
    else $error("add did not advance entry count");

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_q.add_done, out_q.table_full, out_q.found}))
    else $error("conflicting result flags");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.send_stack |-> out_q.stack_addr == 8'd0)
    else $error("stack address set without send_stack");
`endif

endmodule

`default_nettype wire
